// File: hw/rtl/time_window_coincidence_finder_top_defines.svh
// assertion macros for the time window coincidence finder
// used by time_window_coincidence_finder_top; no other dependencies
`ifndef TIME_WINDOW_COINCIDENCE_FINDER_TOP_DEFINES_SVH
`define TIME_WINDOW_COINCIDENCE_FINDER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TWCF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TWCF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/twcf_pkg.sv
// shared types and constants of the time window coincidence finder
// no dependencies
package twcf_pkg;

   localparam int NUM_CELLS_DEF      = 1024;
   localparam int SLOTS_PER_CELL_DEF = 16;

   localparam int TIME_W  = 48;
   localparam int WIDTH_W = 32;
   localparam int INDEX_W = 24;
   localparam int DIFF_W  = 49;
   localparam int CSR_W   = 48;

   localparam logic [TIME_W-1:0]  BASE_RESET   = 48'd0;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 32'd100000000;
   localparam logic [WIDTH_W-1:0] WINDOW_RESET = 32'd100000;

   typedef enum logic [1:0] {
      CSR_BASE   = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_WINDOW = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STAT_MATCH  = 3'd0,
      STAT_NONE   = 3'd1,
      STAT_STORED = 3'd2,
      STAT_RANGE  = 3'd3,
      STAT_FULL   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_LFILL_RD,
      S_LFILL_WT,
      S_CELL,
      S_QFILL_WT,
      S_SLOT_RD,
      S_SLOT_WT,
      S_FINISH
   } state_type;

endpackage

// File: hw/rtl/twcf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module twcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/twcf_div.sv
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module twcf_div #(
   parameter int DW = 48,
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] num_ff, num_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [VW:0]   shifted;
   logic [VW:0]   trial;

   always_comb begin
      shifted = {rem_ff, num_ff[DW-1]};
      trial   = shifted - {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         num_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         if (!trial[VW]) begin
            rem_in = trial[VW-1:0];
         end else begin
            rem_in = shifted[VW-1:0];
         end
         num_in = {num_ff[DW-2:0], ~trial[VW]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

// File: hw/rtl/time_window_coincidence_finder_top.sv
// time window coincidence finder: top level with sequencer and cell store
// uses twcf_pkg, twcf_div, twcf_ram and the assertion macro header
//
// usage
// - input beat: req_operation, req_event_time, req_event_index taken when
//   start is high and busy is low; busy is low again in the cycle of the
//   last result, so the next beat can be taken there
// - result beats: rsp_strobe marks each result for one cycle, rsp_last on
//   the final one of an input; the receiver cannot stall the block
// - csr port: csr_write with csr_index selects base, cell width, window;
//   to be written by the user only while busy is low; not enforced here
// - sequence: a load before base is answered without the divider; other
//   inputs run the 48-step divider that finds the cell; a load beyond the
//   grid is then answered, other loads read the fill ram and store the
//   event unless the cell is full; a query too far off the grid goes to
//   its final result, else it reads the fill count of each of the three
//   candidate cells around its cell that lie in the grid, and each slot
// - reset: a clearing pass zeroes the fill counts of all NUM_CELLS cells;
//   busy is high meanwhile, configuration writes are still taken
`include "time_window_coincidence_finder_top_defines.svh"

module time_window_coincidence_finder_top
   import twcf_pkg::*;
#(
   parameter int NUM_CELLS      = NUM_CELLS_DEF,
   parameter int SLOTS_PER_CELL = SLOTS_PER_CELL_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_operation,
   input  logic [TIME_W-1:0]         req_event_time,
   input  logic [INDEX_W-1:0]        req_event_index,
   output logic                      rsp_strobe,
   output logic [2:0]                rsp_status,
   output logic [INDEX_W-1:0]        rsp_matched_index,
   output logic signed [DIFF_W-1:0]  rsp_time_difference,
   output logic                      rsp_last,
   input  logic                      csr_write,
   input  logic [1:0]                csr_index,
   input  logic [CSR_W-1:0]          csr_data
);

   localparam int CI    = $clog2(NUM_CELLS);
   localparam int CCW   = $clog2(NUM_CELLS + 2) + 1;
   localparam int FW    = $clog2(SLOTS_PER_CELL + 1);
   localparam int DEPTH = NUM_CELLS * SLOTS_PER_CELL;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = TIME_W + INDEX_W;

   state_type state_ff, state_in;

   logic [TIME_W-1:0]  base_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic [WIDTH_W-1:0] window_ff;

   logic                   op_ff, op_in;
   logic [TIME_W-1:0]      time_ff, time_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic                   neg_ff, neg_in;
   logic signed [CCW-1:0]  centre_ff, centre_in;
   logic [CI-1:0]          cell_ff, cell_in;
   logic [1:0]             k_ff, k_in;
   logic [FW-1:0]          fill_ff, fill_in;
   logic [FW-1:0]          slot_ff, slot_in;
   logic [CI-1:0]          clr_ff, clr_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [INDEX_W-1:0]     pend_index_ff, pend_index_in;
   logic [DIFF_W-1:0]      pend_diff_ff, pend_diff_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [DIFF_W-1:0]      rsp_diff_ff, rsp_diff_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   below_base;
   logic [TIME_W-1:0]      dividend;
   logic [WIDTH_W-1:0]     divisor;
   logic                   div_start;
   logic                   div_done;
   logic [TIME_W-1:0]      quotient;
   logic                   q_out;
   logic                   query_skip;
   logic signed [CCW-1:0]  cand;
   logic                   cand_ok;
   logic                   more_slots;

   logic                   fill_we;
   logic [CI-1:0]          fill_wa;
   logic [FW-1:0]          fill_wd;
   logic [CI-1:0]          fill_ra;
   logic [FW-1:0]          fill_rd;
   logic                   slot_we;
   logic [AW-1:0]          slot_wa;
   logic [SW-1:0]          slot_wd;
   logic [AW-1:0]          slot_ra;
   logic [SW-1:0]          slot_rd;
   logic [TIME_W-1:0]      slot_time;
   logic [DIFF_W-1:0]      diff;
   logic [DIFF_W-1:0]      mag;
   logic                   hit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_RESET;
         width_ff  <= WIDTH_RESET;
         window_ff <= WINDOW_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BASE:   base_ff   <= csr_data[TIME_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_data[WIDTH_W-1:0];
            CSR_WINDOW: window_ff <= csr_data[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign below_base = (req_event_time < base_ff);
   assign dividend   = below_base ? (base_ff - req_event_time - 1'b1)
                                  : (req_event_time - base_ff);
   assign divisor    = (width_ff == '0) ? WIDTH_W'(1) : width_ff;
   assign q_out      = (quotient >= TIME_W'(NUM_CELLS));
   assign query_skip = div_done && (op_ff == OP_QUERY) &&
                       (neg_ff ? (quotient != '0) : (quotient > TIME_W'(NUM_CELLS)));
   assign cand       = centre_ff + $signed({{(CCW-2){1'b0}}, k_ff}) - CCW'(1);
   assign cand_ok    = !cand[CCW-1] && (cand < $signed(CCW'(NUM_CELLS)));
   assign more_slots = (FW'(slot_ff + 1'b1) < fill_ff);

   assign slot_time = slot_rd[SW-1:INDEX_W];
   assign diff      = {1'b0, time_ff} - {1'b0, slot_time};
   assign mag       = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
   assign hit       = (mag <= DIFF_W'(window_ff));

   twcf_div #(
      .DW (TIME_W),
      .VW (WIDTH_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   twcf_ram #(
      .WIDTH (FW),
      .DEPTH (NUM_CELLS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_wa),
      .wr_data (fill_wd),
      .rd_addr (fill_ra),
      .rd_data (fill_rd)
   );

   twcf_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_addr (slot_ra),
      .rd_data (slot_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == CI'(NUM_CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept && !(req_operation == OP_LOAD && below_base)) state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               if (op_ff == OP_LOAD) begin
                  state_in = q_out ? S_IDLE : S_LFILL_RD;
               end else begin
                  priority if (neg_ff && quotient != '0) state_in = S_FINISH;
                  else if (!neg_ff && quotient > TIME_W'(NUM_CELLS)) state_in = S_FINISH;
                  else state_in = S_CELL;
               end
            end
         end
         S_LFILL_RD: state_in = S_LFILL_WT;
         S_LFILL_WT: state_in = S_IDLE;
         S_CELL: begin
            priority if (cand_ok) state_in = S_QFILL_WT;
            else if (k_ff == 2'd2) state_in = S_FINISH;
            else state_in = S_CELL;
         end
         S_QFILL_WT: begin
            priority if (fill_rd != '0) state_in = S_SLOT_RD;
            else if (k_ff == 2'd2) state_in = S_FINISH;
            else state_in = S_CELL;
         end
         S_SLOT_RD: state_in = S_SLOT_WT;
         S_SLOT_WT: begin
            priority if (more_slots) state_in = S_SLOT_RD;
            else if (k_ff == 2'd2) state_in = S_FINISH;
            else state_in = S_CELL;
         end
         S_FINISH: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // ram and divider controls
   always_comb begin
      div_start = 1'b0;
      fill_we   = 1'b0;
      fill_wa   = cell_ff;
      fill_wd   = FW'(fill_rd + 1'b1);
      fill_ra   = cell_ff;
      slot_we   = 1'b0;
      slot_wa   = AW'(AW'(cell_ff) * AW'(SLOTS_PER_CELL) + AW'(fill_rd));
      slot_wd   = {time_ff, index_ff};
      slot_ra   = AW'(AW'(cell_ff) * AW'(SLOTS_PER_CELL) + AW'(slot_ff));
      unique case (state_ff)
         S_CLEAR: begin
            fill_we = 1'b1;
            fill_wa = clr_ff;
            fill_wd = '0;
         end
         S_IDLE: begin
            div_start = accept && !(req_operation == OP_LOAD && below_base);
         end
         S_LFILL_WT: begin
            if (fill_rd < FW'(SLOTS_PER_CELL)) begin
               fill_we = 1'b1;
               slot_we = 1'b1;
            end
         end
         S_CELL: begin
            fill_ra = cand[CI-1:0];
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      op_in         = op_ff;
      time_in       = time_ff;
      index_in      = index_ff;
      neg_in        = neg_ff;
      centre_in     = centre_ff;
      cell_in       = cell_ff;
      k_in          = k_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      clr_in        = clr_ff;
      pend_valid_in = pend_valid_ff;
      pend_index_in = pend_index_ff;
      pend_diff_in  = pend_diff_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = '0;
      rsp_diff_in   = '0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         S_CLEAR: clr_in = CI'(clr_ff + 1'b1);
         S_IDLE: begin
            if (accept) begin
               op_in         = req_operation;
               time_in       = req_event_time;
               index_in      = req_event_index;
               neg_in        = below_base;
               pend_valid_in = 1'b0;
               k_in          = '0;
               if (req_operation == OP_LOAD && below_base) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_RANGE;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               cell_in   = quotient[CI-1:0];
               centre_in = neg_ff ? -$signed(CCW'(1)) : $signed(quotient[CCW-1:0]);
               if (op_ff == OP_LOAD && q_out) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_RANGE;
               end
            end
         end
         S_LFILL_WT: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = (fill_rd < FW'(SLOTS_PER_CELL)) ? STAT_STORED : STAT_FULL;
         end
         S_CELL: begin
            cell_in = cand[CI-1:0];
            if (!cand_ok) k_in = 2'(k_ff + 1'b1);
         end
         S_QFILL_WT: begin
            fill_in = fill_rd;
            slot_in = '0;
            if (fill_rd == '0) k_in = 2'(k_ff + 1'b1);
         end
         S_SLOT_WT: begin
            slot_in = FW'(slot_ff + 1'b1);
            if (!more_slots) k_in = 2'(k_ff + 1'b1);
            if (hit) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_MATCH;
                  rsp_index_in  = pend_index_ff;
                  rsp_diff_in   = pend_diff_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_index_in = slot_rd[INDEX_W-1:0];
               pend_diff_in  = diff;
            end
         end
         S_FINISH: begin
            rsp_strobe_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_status_in = STAT_MATCH;
               rsp_index_in  = pend_index_ff;
               rsp_diff_in   = pend_diff_ff;
            end else begin
               rsp_status_in = STAT_NONE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         k_ff          <= k_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff         <= op_in;
      time_ff       <= time_in;
      index_ff      <= index_in;
      neg_ff        <= neg_in;
      centre_ff     <= centre_in;
      cell_ff       <= cell_in;
      fill_ff       <= fill_in;
      slot_ff       <= slot_in;
      pend_index_ff <= pend_index_in;
      pend_diff_ff  <= pend_diff_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_diff_ff   <= rsp_diff_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_matched_index   = rsp_index_ff;
   assign rsp_time_difference = $signed(rsp_diff_ff);
   assign rsp_last            = rsp_last_ff;

   `TWCF_ASSERT_IMP(a_final_idle, rsp_strobe && rsp_last, !busy, "final beat while busy")
   `TWCF_ASSERT_IMP(a_mid_busy, rsp_strobe && !rsp_last, busy, "early beat after idle")
   `TWCF_ASSERT_IMP(a_nonmatch_last, rsp_strobe && rsp_status != STAT_MATCH, rsp_last, "bad last")
   `TWCF_ASSERT_NXT(a_skip_finish, query_skip, state_ff == S_FINISH, "out of grid query scanned")

endmodule
